[rtl/core/tmdr_pkg.sv]
`default_nettype none
package tmdr_pkg;

  // Field widths
  localparam int ADDR_W = 19;
  localparam int DATA_W = 32;
  localparam int PIX_W  = 16;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // Text grid and mode code
  localparam int          TEXT_COLS      = 80;
  localparam int          TEXT_ROWS      = 30;
  localparam logic [31:0] TEXT_MODE_CODE = 32'd0;

  // Character store is addressed {row[4:0], col[6:0]}
  localparam int CHAR_ROW_W = 5;
  localparam int CHAR_COL_W = 7;
  localparam int CHAR_AW    = CHAR_ROW_W + CHAR_COL_W;
  localparam int CHAR_DEPTH = 1 << CHAR_AW;

  // Font store: glyph*16 + row
  localparam int FONT_AW    = 12;
  localparam int FONT_DEPTH = 1 << FONT_AW;

  // Register addresses
  localparam logic [ADDR_W-1:0] REG_MODE = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_CHAR = ADDR_W'(4);

  typedef enum logic [1:0] {
    CMD_REG_WR  = 2'd0,
    CMD_PIX_WR  = 2'd1,
    CMD_FONT_WR = 2'd2,
    CMD_RENDER  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_addr;
    logic [PIX_W-1:0]  pixel;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FONT,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/tmdr_ram.sv]
`default_nettype none
module tmdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle; rdata holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/tmdr_addr_div.sv]
`default_nettype none
module tmdr_addr_div
  import tmdr_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  localparam int RECIP = (2 ** ADDR_W) / SCREEN_WIDTH,
  localparam int RW    = $clog2(RECIP + 1),
  localparam int YW    = $clog2((2 ** ADDR_W) / SCREEN_WIDTH + 1),
  localparam int XW    = $clog2(SCREEN_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] addr,
  output      logic              done,
  output      logic [YW-1:0]     y,
  output      logic [XW-1:0]     x
);

  logic                 v1, v2;
  logic [ADDR_W-1:0]    a1, a2;
  logic [ADDR_W+RW-1:0] prod1;
  logic [YW-1:0]        q0, q2;
  logic [ADDR_W-1:0]    prod2;
  logic [ADDR_W-1:0]    rem;
  logic                 fix;

  // quotient estimate, low by at most one
  assign q0  = YW'(prod1 >> ADDR_W);
  assign rem = a2 - prod2;
  assign fix = rem >= ADDR_W'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // stage 1: multiply by reciprocal
  // stage 2: back-multiply the estimate
  // stage 3: one correction step
  always_ff @(posedge clk) begin
    a1    <= addr;
    prod1 <= (ADDR_W+RW)'(addr) * (ADDR_W+RW)'(RECIP);
    a2    <= a1;
    q2    <= q0;
    prod2 <= ADDR_W'(32'(q0) * 32'(SCREEN_WIDTH));
    if (v2) begin
      if (fix) begin
        y <= q2 + YW'(1);
        x <= XW'(rem - ADDR_W'(SCREEN_WIDTH));
      end else begin
        y <= q2;
        x <= XW'(rem);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/text_mode_display_renderer_unit.sv]
`default_nettype none
// Text-mode display renderer.
// Input channel (in_valid / in_stall / in_word) carries commands: register
// write, pixel write, font row write and render. Output channel
// (out_valid / out_stall / out_word) carries one word per render whose
// address lies inside the framebuffer.
// A write is done when it is accepted. A render goes from acceptance to the
// output register through the address split (a 3-stage reciprocal divider),
// then a character store read and a font store read, both skipped when no
// glyph is drawn; the next word is accepted in the cycle after the result is
// loaded. One render is in flight at a time, held by the sequencer.
// Reset: text mode is selected and all three memories are cleared by one
// pass over the deepest of them, one entry per cycle, with in_stall high
// throughout.
// A stalled result stays in the output register; a new word is still taken
// meanwhile, and a following render waits in its last step until the
// output register is free.
module text_mode_display_renderer_unit
  import tmdr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_word_t  in_word,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_word_t out_word
);

  localparam int unsigned FB_SIZE   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int          FB_DEPTH  = (FB_SIZE > 2 ** ADDR_W) ? 2 ** ADDR_W : FB_SIZE;
  localparam int          FB_AW     = $clog2(FB_DEPTH);
  localparam int          CLEAR_LEN = (FB_DEPTH > CHAR_DEPTH) ? FB_DEPTH : CHAR_DEPTH;
  localparam int          CLR_W     = $clog2(CLEAR_LEN);
  localparam int          YW        = $clog2((2 ** ADDR_W) / SCREEN_WIDTH + 1);
  localparam int          XW        = $clog2(SCREEN_WIDTH);

  state_t            state, state_next;
  logic [CLR_W-1:0]  clr_cnt;
  logic              text_mode, text_mode_next;
  logic              hit, hit_next;
  logic [ADDR_W-1:0] rnd_addr;
  logic              load_out;

  // memory ports
  logic               fb_we, fb_re;
  logic [FB_AW-1:0]   fb_waddr, fb_raddr;
  logic [PIX_W-1:0]   fb_wdata, fb_rdata;
  logic               ch_we, ch_re;
  logic [CHAR_AW-1:0] ch_waddr, ch_raddr;
  logic [PIX_W-1:0]   ch_wdata, ch_rdata;
  logic               ft_we, ft_re;
  logic [FONT_AW-1:0] ft_waddr, ft_raddr;
  logic [7:0]         ft_wdata, ft_rdata;

  // divider
  logic          div_start, div_done;
  logic [YW-1:0] div_y;
  logic [XW-1:0] div_x;

  // decoded fields
  logic                  in_fb_range;
  logic [CHAR_ROW_W-1:0] wr_row, rd_row;
  logic [CHAR_COL_W-1:0] wr_col, rd_col;
  logic                  wr_cell_ok, rd_cell_ok;
  logic                  font_bit;
  logic [PIX_W-1:0]      txt_pix, pix;

  tmdr_addr_div #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .addr (in_word.addr),
    .done (div_done),
    .y    (div_y),
    .x    (div_x)
  );

  tmdr_ram #(.WIDTH(PIX_W), .DEPTH(FB_DEPTH)) u_frame (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .re(fb_re), .raddr(fb_raddr), .rdata(fb_rdata)
  );

  tmdr_ram #(.WIDTH(PIX_W), .DEPTH(CHAR_DEPTH)) u_char (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .re(ch_re), .raddr(ch_raddr), .rdata(ch_rdata)
  );

  tmdr_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
    .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
    .re(ft_re), .raddr(ft_raddr), .rdata(ft_rdata)
  );

  // field decode
  assign in_fb_range = 32'(in_word.addr) < FB_SIZE;
  assign wr_row      = in_word.data[27:23];
  assign wr_col      = in_word.data[22:16];
  assign wr_cell_ok  = (32'(wr_row) < 32'(TEXT_ROWS)) && (32'(wr_col) < 32'(TEXT_COLS));
  assign rd_row      = CHAR_ROW_W'(32'(div_y) >> 4);
  assign rd_col      = CHAR_COL_W'(32'(div_x) >> 3);
  assign rd_cell_ok  = ((32'(div_y) >> 4) < 32'(TEXT_ROWS)) &&
                       ((32'(div_x) >> 3) < 32'(TEXT_COLS));

  // glyph pixel: font bit 7 is the leftmost
  assign font_bit = ft_rdata[~div_x[2:0]];
  assign txt_pix  = font_bit ? PIX_W'(ch_rdata[15:12]) : PIX_W'(ch_rdata[11:8]);
  assign pix      = hit ? txt_pix : fb_rdata;

  // sequencer
  always_comb begin
    state_next     = state;
    text_mode_next = text_mode;
    hit_next       = hit;
    in_stall       = 1'b1;
    load_out       = 1'b0;
    div_start      = 1'b0;
    fb_we          = 1'b0;
    fb_re          = 1'b0;
    fb_waddr       = in_word.addr[FB_AW-1:0];
    fb_wdata       = in_word.data[PIX_W-1:0];
    fb_raddr       = in_word.addr[FB_AW-1:0];
    ch_we          = 1'b0;
    ch_re          = 1'b0;
    ch_waddr       = {wr_row, wr_col};
    ch_wdata       = in_word.data[PIX_W-1:0];
    ch_raddr       = {rd_row, rd_col};
    ft_we          = 1'b0;
    ft_re          = 1'b0;
    ft_waddr       = in_word.addr[FONT_AW-1:0];
    ft_wdata       = in_word.data[7:0];
    ft_raddr       = {ch_rdata[7:0], div_y[3:0]};
    case (state)
      ST_CLEAR: begin
        fb_we    = 32'(clr_cnt) < 32'(FB_DEPTH);
        fb_waddr = clr_cnt[FB_AW-1:0];
        fb_wdata = '0;
        ch_we    = 32'(clr_cnt) < 32'(CHAR_DEPTH);
        ch_waddr = clr_cnt[CHAR_AW-1:0];
        ch_wdata = '0;
        ft_we    = 32'(clr_cnt) < 32'(FONT_DEPTH);
        ft_waddr = clr_cnt[FONT_AW-1:0];
        ft_wdata = '0;
        if (clr_cnt == CLR_W'(CLEAR_LEN - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_word.cmd)
            CMD_REG_WR: begin
              if (in_word.addr == REG_MODE) begin
                text_mode_next = in_word.data == TEXT_MODE_CODE;
              end
              ch_we = (in_word.addr == REG_CHAR) && wr_cell_ok;
            end
            CMD_PIX_WR: begin
              fb_we = in_fb_range;
            end
            CMD_FONT_WR: begin
              ft_we = 32'(in_word.addr) < 32'(FONT_DEPTH);
            end
            CMD_RENDER: begin
              if (in_fb_range) begin
                fb_re      = 1'b1;
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (text_mode && rd_cell_ok) begin
            ch_re      = 1'b1;
            hit_next   = 1'b1;
            state_next = ST_FONT;
          end else begin
            hit_next   = 1'b0;
            state_next = ST_OUT;
          end
        end
      end
      ST_FONT: begin
        ft_re      = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          fb_we      = hit;
          fb_waddr   = rnd_addr[FB_AW-1:0];
          fb_wdata   = pix;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      text_mode <= 1'b1;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      text_mode <= text_mode_next;
      hit       <= hit_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      rnd_addr <= in_word.addr;
    end
    if (load_out) begin
      out_word.pixel_addr <= rnd_addr;
      out_word.pixel      <= pix;
    end
  end

endmodule
`default_nettype wire
